// ===== rtl/servo_bus_packet_master_core_assert.svh =====
// Assertion macros shared by the servo bus master checker.
`ifndef SERVO_BUS_PACKET_MASTER_CORE_ASSERT_SVH
`define SERVO_BUS_PACKET_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SBPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SBPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbpm_pkg.sv =====
// Shared types, codes and frame helpers of the servo bus master.
package sbpm_pkg;

    localparam logic OP_ISSUE = 1'b0;
    localparam logic OP_RX    = 1'b1;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic {
        PH_IDLE   = 1'b0,
        PH_STATUS = 1'b1
    } t_phase;

    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] BCAST_ID    = 8'hFE;
    localparam logic [7:0] LEN_SHORT   = 8'h04;
    localparam logic [7:0] LEN_LONG    = 8'h05;
    localparam logic [7:0] LEN_RESET   = 8'h02;
    localparam logic [7:0] INS_READ    = 8'h02;
    localparam logic [7:0] INS_WRITE   = 8'h03;
    localparam logic [7:0] INS_RESET   = 8'h06;

    localparam logic [3:0] STAT_LEN_BASE = 4'd6;

    localparam int JOB_DEPTH_DEF = 4;

    // One unit of work for the serialiser: a frame to send or a finished report.
    typedef struct packed {
        logic        is_frame;
        logic [7:0]  id;
        t_cmd        cmd;
        logic [7:0]  reg_addr;
        logic        two;
        logic [15:0] value;
        logic        bcast;
        logic [7:0]  chk;
        logic        status;
        logic [7:0]  servo_error;
        logic [15:0] read_data;
    } t_job;

    function automatic logic [3:0] frame_len(t_job j);
        logic [3:0] n;
        unique case (j.cmd)
            CMD_READ:  n = 4'd8;
            CMD_WRITE: n = j.two ? 4'd9 : 4'd8;
            default:   n = 4'd6;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] len_byte(t_cmd cmd, logic two);
        logic [7:0] b;
        unique case (cmd)
            CMD_READ:  b = LEN_SHORT;
            CMD_WRITE: b = two ? LEN_LONG : LEN_SHORT;
            default:   b = LEN_RESET;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] instr_byte(t_cmd cmd);
        logic [7:0] b;
        unique case (cmd)
            CMD_READ:  b = INS_READ;
            CMD_WRITE: b = INS_WRITE;
            default:   b = INS_RESET;
        endcase
        return b;
    endfunction

    // Byte idx of the outgoing frame; the last position carries the checksum.
    function automatic logic [7:0] frame_byte(t_job j, logic [3:0] idx);
        logic [7:0] b;
        b = HDR_BYTE;
        if (idx == frame_len(j) - 4'd1) begin
            b = j.chk;
        end else begin
            unique case (idx)
                4'd2: b = j.id;
                4'd3: b = len_byte(j.cmd, j.two);
                4'd4: b = instr_byte(j.cmd);
                4'd5: b = j.reg_addr;
                4'd6: b = (j.cmd == CMD_READ) ? (j.two ? 8'd2 : 8'd1) : j.value[7:0];
                4'd7: b = j.value[15:8];
                default: b = HDR_BYTE;
            endcase
        end
        return b;
    endfunction

endpackage

// ===== rtl/sbpm_front.sv =====
// Front end: classify items, track the status packet, build serialiser jobs.
module sbpm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_op,
    input  logic [7:0]       i_servo_id,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_reg_addr,
    input  logic [1:0]       i_byte_len,
    input  logic [15:0]      i_write_value,
    input  logic [7:0]       i_rx_byte,
    output logic             o_job_valid,
    output sbpm_pkg::t_job   o_job
);
    import sbpm_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_exp_id,  n_exp_id;
    logic [3:0]  r_exp_len, n_exp_len;
    logic [3:0]  r_count,   n_count;
    logic [7:0]  r_sum,     n_sum;
    logic        r_id_bad,  n_id_bad;
    logic [7:0]  r_err,     n_err;
    logic [15:0] r_data,    n_data;

    t_cmd        cmd;
    logic        two;
    logic        is_issue;
    logic        is_cmd;
    logic        in_status;
    logic        last_byte;
    logic        bad;
    logic [7:0]  param_sum;
    logic [7:0]  chk_sum;

    assign cmd       = t_cmd'(i_command);
    assign two       = i_byte_len[1];
    assign is_issue  = (i_op == OP_ISSUE);
    assign is_cmd    = is_issue && (cmd != CMD_NONE);
    assign in_status = (r_phase == PH_STATUS);
    assign last_byte = ({1'b0, r_count} + 5'd1) >= {1'b0, r_exp_len};
    assign bad       = r_id_bad || (~r_sum != i_rx_byte);

    // Parameter contribution to the checksum
    always_comb begin
        unique case (cmd)
            CMD_READ:  param_sum = i_reg_addr + (two ? 8'd2 : 8'd1);
            CMD_WRITE: param_sum = i_reg_addr + i_write_value[7:0]
                                   + (two ? i_write_value[15:8] : 8'd0);
            default:   param_sum = 8'd0;
        endcase
        chk_sum = i_servo_id + len_byte(cmd, two) + instr_byte(cmd) + param_sum;
    end

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (is_cmd) begin
                n_phase = (i_servo_id == BCAST_ID) ? PH_IDLE : PH_STATUS;
            end else if (!is_issue && in_status && last_byte) begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_comb begin
        n_exp_id  = r_exp_id;
        n_exp_len = r_exp_len;
        n_count   = r_count;
        n_sum     = r_sum;
        n_id_bad  = r_id_bad;
        n_err     = r_err;
        n_data    = r_data;
        if (i_accept && is_cmd) begin
            n_count  = '0;
            n_sum    = '0;
            n_id_bad = 1'b0;
            n_err    = '0;
            n_data   = '0;
            if (i_servo_id == BCAST_ID) begin
                n_exp_id  = '0;
                n_exp_len = '0;
            end else begin
                n_exp_id  = i_servo_id;
                n_exp_len = (cmd == CMD_READ) ? (two ? 4'd8 : 4'd7) : STAT_LEN_BASE;
            end
        end else if (i_accept && !is_issue && in_status) begin
            if (last_byte) begin
                n_exp_id  = '0;
                n_exp_len = '0;
                n_count   = '0;
                n_sum     = '0;
                n_id_bad  = 1'b0;
                n_err     = '0;
                n_data    = '0;
            end else begin
                if (r_count >= 4'd2) n_sum = r_sum + i_rx_byte;
                if (r_count == 4'd2 && i_rx_byte != r_exp_id) n_id_bad = 1'b1;
                if (r_count == 4'd4) n_err = i_rx_byte;
                if (r_count == 4'd5) n_data[7:0] = i_rx_byte;
                if (r_count == 4'd6) n_data[15:8] = i_rx_byte;
                n_count = r_count + 4'd1;
            end
        end
    end

    always_comb begin
        o_job_valid       = i_accept && (is_cmd || (!is_issue && in_status && last_byte));
        o_job.is_frame    = is_issue;
        o_job.id          = i_servo_id;
        o_job.cmd         = cmd;
        o_job.reg_addr    = i_reg_addr;
        o_job.two         = two;
        o_job.value       = i_write_value;
        o_job.bcast       = (i_servo_id == BCAST_ID);
        o_job.chk         = ~chk_sum;
        o_job.status      = bad;
        o_job.servo_error = bad ? 8'd0 : r_err;
        o_job.read_data   = bad ? 16'd0 : r_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_exp_id  <= '0;
            r_exp_len <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_id_bad  <= 1'b0;
            r_err     <= '0;
            r_data    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_exp_id  <= n_exp_id;
            r_exp_len <= n_exp_len;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_id_bad  <= n_id_bad;
            r_err     <= n_err;
            r_data    <= n_data;
        end
    end

endmodule

// ===== rtl/sbpm_jobq.sv =====
// Short job queue between the front end and the serialiser.
module sbpm_jobq #(
    parameter int Depth = sbpm_pkg::JOB_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  sbpm_pkg::t_job   i_wr_job,
    output logic             o_full,
    output logic             o_valid,
    output sbpm_pkg::t_job   o_rd_job,
    input  logic             i_rd
);
    import sbpm_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    t_job          r_mem [Depth];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic          do_wr;
    logic          do_rd;

    assign o_full   = (r_cnt == CW'(Depth));
    assign o_valid  = (r_cnt != '0);
    assign o_rd_job = r_mem[r_rptr];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_wr) n_wptr = (r_wptr == AW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
        if (do_rd) n_rptr = (r_rptr == AW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
        if (do_wr && !do_rd) n_cnt = r_cnt + 1'b1;
        else if (do_rd && !do_wr) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wptr] <= i_wr_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/sbpm_back.sv =====
// Serialiser: walk each job out as frame bytes or a finished report.
module sbpm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  sbpm_pkg::t_job   i_job,
    output logic             o_job_pop,
    output logic             o_valid,
    input  logic             i_take,
    output logic             o_kind,
    output logic [7:0]       o_tx_byte,
    output logic             o_last_tx,
    output logic             o_status,
    output logic [7:0]       o_servo_error,
    output logic [15:0]      o_read_data
);
    import sbpm_pkg::*;

    logic [3:0]  r_idx, n_idx;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_tx_byte;
    logic        r_last_tx;
    logic        r_status;
    logic [7:0]  r_servo_error;
    logic [15:0] r_read_data;

    logic        advance;
    logic        done;
    logic [3:0]  n_len;
    logic        c_kind;
    logic [7:0]  c_tx_byte;
    logic        c_last_tx;
    logic        c_status;
    logic [7:0]  c_servo_error;
    logic [15:0] c_read_data;

    assign advance = i_job_valid && (!r_valid || i_take);
    assign n_len   = frame_len(i_job);

    always_comb begin
        c_kind        = KIND_DONE;
        c_tx_byte     = '0;
        c_last_tx     = 1'b0;
        c_status      = 1'b0;
        c_servo_error = '0;
        c_read_data   = '0;
        done          = 1'b1;
        if (i_job.is_frame) begin
            if (r_idx < n_len) begin
                c_kind    = KIND_TX;
                c_tx_byte = frame_byte(i_job, r_idx);
                c_last_tx = (r_idx == n_len - 4'd1);
                done      = c_last_tx && !i_job.bcast;
            end
        end else begin
            c_status      = i_job.status;
            c_servo_error = i_job.servo_error;
            c_read_data   = i_job.read_data;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (advance) n_idx = done ? 4'd0 : r_idx + 4'd1;
    end

    assign o_job_pop = advance && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (advance) r_valid <= 1'b1;
            else if (i_take) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind        <= c_kind;
            r_tx_byte     <= c_tx_byte;
            r_last_tx     <= c_last_tx;
            r_status      <= c_status;
            r_servo_error <= c_servo_error;
            r_read_data   <= c_read_data;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx_byte;
    assign o_last_tx     = r_last_tx;
    assign o_status      = r_status;
    assign o_servo_error = r_servo_error;
    assign o_read_data   = r_read_data;

endmodule

// ===== rtl/servo_bus_packet_master_core.sv =====
// Top level of the servo bus master: front end, job queue and serialiser.
//
// Use: items enter through a queue-like port (push/full). An item is either a
// command (op 0: read, write or factory reset) or one received status byte
// (op 1). Results leave through a queue-like port (empty/pop): frame bytes to
// transmit, each with last_tx on the checksum byte, and a finished report
// carrying status, the servo error byte and the read data.
// An accepted item's job is written into the job queue and the serialiser
// registers its first result from the queue head. A command frame then leaves
// at one byte a cycle while the receiver pops, 6 to 9 bytes, plus one finished
// report after a broadcast frame. Throughput: one item is taken every cycle
// while the job queue has room; the serialiser, one byte per cycle while the
// receiver pops, sets the sustained command rate. Status bytes cost the
// serialiser nothing until the last one, which yields one report.
// Reset (synchronous, active low) drops any pending transaction, empties the
// job queue and the output register.
// When the receiver stalls (pop low) the result held on the ports stays put;
// the queue keeps absorbing items until it fills, then full rises.
module servo_bus_packet_master_core #(
    parameter int JobDepth = sbpm_pkg::JOB_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_servo_id,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_reg_addr,
    input  logic [1:0]  i_byte_len,
    input  logic [15:0] i_write_value,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_tx,
    output logic        o_status,
    output logic [7:0]  o_servo_error,
    output logic [15:0] o_read_data
);
    import sbpm_pkg::*;

    logic  accept;
    logic  q_full;
    logic  fe_job_valid;
    t_job  fe_job;
    logic  q_valid;
    t_job  q_job;
    logic  be_pop;
    logic  be_valid;

    // Take an item only when the queue can hold whatever job it makes
    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !be_valid;

    sbpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_servo_id    (i_servo_id),
        .i_command     (i_command),
        .i_reg_addr    (i_reg_addr),
        .i_byte_len    (i_byte_len),
        .i_write_value (i_write_value),
        .i_rx_byte     (i_rx_byte),
        .o_job_valid   (fe_job_valid),
        .o_job         (fe_job)
    );

    sbpm_jobq #(
        .Depth (JobDepth)
    ) u_jobq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (fe_job_valid),
        .i_wr_job (fe_job),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_rd_job (q_job),
        .i_rd     (be_pop)
    );

    sbpm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_job_pop     (be_pop),
        .o_valid       (be_valid),
        .i_take        (pop),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_last_tx     (o_last_tx),
        .o_status      (o_status),
        .o_servo_error (o_servo_error),
        .o_read_data   (o_read_data)
    );

endmodule

// ===== rtl/sbpm_checker.sv =====
// Port-level checker for the servo bus master, bound to the top level.
`include "servo_bus_packet_master_core_assert.svh"

module sbpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_kind,
    input logic [7:0]  o_tx_byte,
    input logic        o_last_tx,
    input logic        o_status,
    input logic [7:0]  o_servo_error,
    input logic [15:0] o_read_data
);
    import sbpm_pkg::*;

    `SBPM_ASSERT_NXT(a_hold_stalled, !empty && !pop, !empty && $stable(o_kind) && $stable(o_tx_byte) && $stable(o_last_tx), "stalled result changed")
    `SBPM_ASSERT_IMP(a_tx_clean, !empty && o_kind == KIND_TX, o_status == 1'b0 && o_servo_error == 8'd0 && o_read_data == 16'd0, "frame byte carries report fields")
    `SBPM_ASSERT_IMP(a_done_clean, !empty && o_kind == KIND_DONE, o_tx_byte == 8'd0 && o_last_tx == 1'b0, "report carries frame fields")
    `SBPM_ASSERT_IMP(a_fail_clean, !empty && o_kind == KIND_DONE && o_status, o_servo_error == 8'd0 && o_read_data == 16'd0, "failed report carries data")
    `SBPM_ASSERT_IMP(a_reset_empty, !$past(i_rst_n), empty, "results present right after reset")

endmodule

bind servo_bus_packet_master_core sbpm_checker u_sbpm_checker (.*);

// ===== dv/servo_bus_packet_master_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the servo bus packet master core.
module servo_bus_packet_master_core_test;
    import sbpm_pkg::*;

    localparam int TOTAL_ITEMS  = 230;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    // How a generated status reply is spoilt, if at all.
    typedef enum int {
        REPLY_GOOD,
        REPLY_BAD_ID,
        REPLY_BAD_SUM
    } t_reply_flaw;

    // One item on the input side: a command or one received status byte.
    typedef struct packed {
        logic        op;
        logic [7:0]  servo_id;
        t_cmd        command;
        logic [7:0]  reg_addr;
        logic [1:0]  byte_len;
        logic [15:0] write_value;
        logic [7:0]  rx_byte;
    } t_bus_item;

    // One item on the result side: a frame byte or a finished report.
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last_tx;
        logic        status;
        logic [7:0]  servo_error;
        logic [15:0] read_data;
    } t_bus_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic        i_op          = OP_ISSUE;
    logic [7:0]  i_servo_id    = 8'h00;
    logic [1:0]  i_command     = CMD_READ;
    logic [7:0]  i_reg_addr    = 8'h00;
    logic [1:0]  i_byte_len    = 2'd1;
    logic [15:0] i_write_value = 16'h0000;
    logic [7:0]  i_rx_byte     = 8'h00;
    logic        empty;
    logic        pop           = 1'b0;
    logic        o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last_tx;
    logic        o_status;
    logic [7:0]  o_servo_error;
    logic [15:0] o_read_data;

    // Items still to be offered, and the results the link is known to owe.
    t_bus_item   cmd_and_rx_items[$];
    t_bus_result bus_results_due[$];
    t_bus_result due;

    // Own copy of the transaction state of the master.
    t_phase      link_phase  = PH_IDLE;
    logic [7:0]  link_id     = 8'h00;
    logic [3:0]  link_len    = 4'd0;
    logic [3:0]  link_count  = 4'd0;
    logic [7:0]  link_sum    = 8'h00;
    logic        link_id_bad = 1'b0;
    logic [7:0]  link_error  = 8'h00;
    logic [15:0] link_data   = 16'h0000;

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          pattern_age    = 0;
    logic [15:0] pop_pattern    = 16'hFFFF;

    servo_bus_packet_master_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_servo_id    (i_servo_id),
        .i_command     (i_command),
        .i_reg_addr    (i_reg_addr),
        .i_byte_len    (i_byte_len),
        .i_write_value (i_write_value),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_last_tx     (o_last_tx),
        .o_status      (o_status),
        .o_servo_error (o_servo_error),
        .o_read_data   (o_read_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drop any pending transaction in the own copy of the state.
    task automatic clear_master_txn();
        link_phase  = PH_IDLE;
        link_id     = 8'h00;
        link_len    = 4'd0;
        link_count  = 4'd0;
        link_sum    = 8'h00;
        link_id_bad = 1'b0;
        link_error  = 8'h00;
        link_data   = 16'h0000;
    endtask

    // Advance the master by one accepted item and queue the results it owes.
    task automatic advance_master(input t_bus_item it);
        logic [7:0] fr [9];
        int         n;
        int         rlen;
        logic       two;
        logic [7:0] sum;
        logic       bad;
        if (it.op == OP_ISSUE) begin
            // The unused command code leaves everything as it was.
            if (it.command != CMD_NONE) begin
                // Length 0 saturates to one byte and 3 to two: only bit 1 counts.
                two   = it.byte_len[1];
                fr[0] = HDR_BYTE;
                fr[1] = HDR_BYTE;
                fr[2] = it.servo_id;
                fr[5] = it.reg_addr;
                rlen  = STAT_LEN_BASE;
                n     = 6;
                case (it.command)
                    CMD_READ: begin
                        fr[3] = LEN_SHORT;
                        fr[4] = INS_READ;
                        fr[6] = two ? 8'd2 : 8'd1;
                        n     = 8;
                        rlen  = STAT_LEN_BASE + (two ? 2 : 1);
                    end
                    CMD_WRITE: begin
                        fr[3] = two ? LEN_LONG : LEN_SHORT;
                        fr[4] = INS_WRITE;
                        fr[6] = it.write_value[7:0];
                        fr[7] = it.write_value[15:8];
                        n     = two ? 9 : 8;
                    end
                    default: begin
                        fr[3] = LEN_RESET;
                        fr[4] = INS_RESET;
                    end
                endcase
                // Inverted sum over id up to the last parameter closes the frame.
                sum = 8'h00;
                for (int i = 2; i < n - 1; i++) begin
                    sum = sum + fr[i];
                end
                fr[n - 1] = ~sum;
                for (int i = 0; i < n; i++) begin
                    bus_results_due.push_back('{KIND_TX, fr[i], (i == n - 1), 1'b0, 8'h00,
                                                16'h0000});
                end
                // A new command abandons whatever was pending.
                clear_master_txn();
                if (it.servo_id == BCAST_ID) begin
                    bus_results_due.push_back('{KIND_DONE, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000});
                end else begin
                    link_phase = PH_STATUS;
                    link_id    = it.servo_id;
                    link_len   = 4'(rlen);
                end
            end
        end else if (link_phase == PH_STATUS) begin
            if (int'(link_count) + 1 >= int'(link_len)) begin
                // Last status byte is the checksum: report and go idle.
                bad = link_id_bad || (~link_sum != it.rx_byte);
                bus_results_due.push_back('{KIND_DONE, 8'h00, 1'b0, bad,
                                            bad ? 8'h00 : link_error,
                                            bad ? 16'h0000 : link_data});
                clear_master_txn();
            end else begin
                if (link_count >= 4'd2) begin
                    link_sum = link_sum + it.rx_byte;
                end
                if (link_count == 4'd2 && it.rx_byte != link_id) begin
                    link_id_bad = 1'b1;
                end
                if (link_count == 4'd4) begin
                    link_error = it.rx_byte;
                end
                if (link_count == 4'd5) begin
                    link_data[7:0] = it.rx_byte;
                end
                if (link_count == 4'd6) begin
                    link_data[15:8] = it.rx_byte;
                end
                link_count = link_count + 4'd1;
            end
        end
    endtask

    // Fill every field at random; callers then pin the fields that matter.
    function automatic t_bus_item random_item();
        t_bus_item it;
        it.op          = 1'($urandom_range(0, 1));
        it.servo_id    = 8'($urandom_range(0, 255));
        it.command     = t_cmd'($urandom_range(0, 3));
        it.reg_addr    = 8'($urandom_range(0, 255));
        it.byte_len    = 2'($urandom_range(0, 3));
        it.write_value = 16'($urandom_range(0, 65535));
        it.rx_byte     = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic queue_command(input logic [7:0] id, input t_cmd cmd, input logic [7:0] addr,
                                 input logic [1:0] blen, input logic [15:0] value);
        t_bus_item it;
        it             = random_item();
        it.op          = OP_ISSUE;
        it.servo_id    = id;
        it.command     = cmd;
        it.reg_addr    = addr;
        it.byte_len    = blen;
        it.write_value = value;
        cmd_and_rx_items.push_back(it);
    endtask

    task automatic queue_rx(input logic [7:0] b);
        t_bus_item it;
        it         = random_item();
        it.op      = OP_RX;
        it.rx_byte = b;
        cmd_and_rx_items.push_back(it);
    endtask

    // Queue a whole status packet of the length the command asks for.
    task automatic queue_reply(input logic [7:0] id, input t_cmd cmd, input logic two,
                               input t_reply_flaw flaw);
        logic [7:0] pkt [8];
        int         len;
        logic [7:0] sum;
        len = (cmd == CMD_READ) ? (two ? 8 : 7) : 6;
        for (int i = 0; i < 8; i++) begin
            pkt[i] = 8'($urandom_range(0, 255));
        end
        // Header bytes go unchecked, so now and then leave one scrambled.
        if ($urandom_range(0, 3) != 0) begin
            pkt[0] = HDR_BYTE;
        end
        pkt[1] = HDR_BYTE;
        pkt[2] = (flaw == REPLY_BAD_ID) ? (id ^ 8'($urandom_range(1, 255))) : id;
        pkt[3] = 8'(len - 4);
        if ($urandom_range(0, 2) != 0) begin
            pkt[4] = 8'h00;
        end
        sum = 8'h00;
        for (int i = 2; i < len - 1; i++) begin
            sum = sum + pkt[i];
        end
        pkt[len - 1] = (flaw == REPLY_BAD_SUM) ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum;
        for (int i = 0; i < len; i++) begin
            queue_rx(pkt[i]);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
            end
        end
    endtask

    // Driver: offer items in bursts of random length with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            // Accepted item: advance the own copy of the master and retire it.
            if (push && !full) begin
                advance_master(cmd_and_rx_items[0]);
                void'(cmd_and_rx_items.pop_front());
            end
            if (push && full) begin
                // Hold the offered item until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (cmd_and_rx_items.size() == 0) begin
                push <= 1'b0;
            end else begin
                push          <= 1'b1;
                i_op          <= cmd_and_rx_items[0].op;
                i_servo_id    <= cmd_and_rx_items[0].servo_id;
                i_command     <= cmd_and_rx_items[0].command;
                i_reg_addr    <= cmd_and_rx_items[0].reg_addr;
                i_byte_len    <= cmd_and_rx_items[0].byte_len;
                i_write_value <= cmd_and_rx_items[0].write_value;
                i_rx_byte     <= cmd_and_rx_items[0].rx_byte;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // Pick the next burst: now and then a long stretch with no gaps.
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left = 64;
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            8, 9:    gap_left = $urandom_range(5, 20);
                            default: gap_left = $urandom_range(1, 4);
                        endcase
                    end
                end
            end
        end
    end

    // Monitor: take results on a stall pattern of its own and check each field.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (bus_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing due, expected none, got kind %0h",
                                 $realtime, o_kind);
                    end
                end else begin
                    due = bus_results_due.pop_front();
                    compare_field("kind", 16'(due.kind), 16'(o_kind));
                    compare_field("tx_byte", 16'(due.tx_byte), 16'(o_tx_byte));
                    compare_field("last_tx", 16'(due.last_tx), 16'(o_last_tx));
                    compare_field("status", 16'(due.status), 16'(o_status));
                    compare_field("servo_error", 16'(due.servo_error), 16'(o_servo_error));
                    compare_field("read_data", due.read_data, o_read_data);
                end
            end
            // Reload the stall pattern now and then; a quarter of the time never stall.
            pattern_age++;
            if (pattern_age >= 48) begin
                pattern_age = 0;
                pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : 16'($urandom_range(1, 65535));
            end
            pop <= pop_pattern[0];
            pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
        end
    end

    // Watchdog: end a run that has hung.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("servo_bus_packet_master_core_test: errors");
            $finish;
        end
    end

    initial begin
        int          pick;
        logic [7:0]  id;
        t_cmd        cmd;
        logic [1:0]  blen;
        t_reply_flaw flaw;

        // Directed opening: idle noise, broadcasts, saturated lengths, extremes,
        // a bad id, a bad checksum and an abandoned read.
        queue_rx(8'hA5);
        queue_command(8'h10, CMD_NONE, 8'h00, 2'd1, 16'h0000);
        queue_command(BCAST_ID, CMD_RESET, 8'h00, 2'd1, 16'h0000);
        queue_command(BCAST_ID, CMD_WRITE, 8'hFF, 2'd2, 16'hFFFF);
        queue_command(8'h00, CMD_READ, 8'h00, 2'd3, 16'h0000);
        queue_reply(8'h00, CMD_READ, 1'b1, REPLY_GOOD);
        queue_command(8'hFF, CMD_WRITE, 8'h80, 2'd0, 16'h00FF);
        queue_reply(8'hFF, CMD_WRITE, 1'b0, REPLY_BAD_ID);
        queue_command(8'h7F, CMD_READ, 8'h2B, 2'd1, 16'hFF00);
        queue_rx(8'hFF);
        queue_rx(8'hFF);
        // Unused code while awaiting status: the read stays pending.
        queue_command(8'h7F, CMD_NONE, 8'h00, 2'd2, 16'h1234);
        // Factory reset abandons the pending read.
        queue_command(8'h01, CMD_RESET, 8'h55, 2'd1, 16'h0000);
        queue_reply(8'h01, CMD_RESET, 1'b0, REPLY_BAD_SUM);

        // Random part: mostly complete transactions with random content.
        while (cmd_and_rx_items.size() < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            id   = 8'($urandom_range(0, 255));
            if (id == BCAST_ID) begin
                id = 8'hFF;
            end
            cmd  = t_cmd'($urandom_range(0, 2));
            blen = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                               : 2'($urandom_range(1, 2));
            if (pick < 70) begin
                queue_command(id, cmd, 8'($urandom), blen, 16'($urandom));
                flaw = ($urandom_range(0, 6) == 0) ? t_reply_flaw'($urandom_range(1, 2))
                                                   : REPLY_GOOD;
                queue_reply(id, cmd, blen[1], flaw);
            end else if (pick < 80) begin
                queue_command(BCAST_ID, cmd, 8'($urandom), blen, 16'($urandom));
            end else if (pick < 88) begin
                // Partial reply, cut short by whatever command comes next.
                queue_command(id, cmd, 8'($urandom), blen, 16'($urandom));
                repeat ($urandom_range(0, 5)) begin
                    queue_rx(8'($urandom));
                end
            end else if (pick < 94) begin
                queue_command(id, CMD_NONE, 8'($urandom), blen, 16'($urandom));
            end else begin
                queue_rx(8'($urandom));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to go in and every owed result to come out,
        // then give the serialiser time to show anything spurious.
        while (cmd_and_rx_items.size() != 0) @(posedge i_clk);
        while (bus_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("servo_bus_packet_master_core_test: clean");
        end else begin
            $display("servo_bus_packet_master_core_test: errors");
        end
        $finish;
    end

endmodule

// ===== servo_bus_packet_master_core.f =====
+incdir+rtl
rtl/sbpm_pkg.sv
rtl/sbpm_front.sv
rtl/sbpm_jobq.sv
rtl/sbpm_back.sv
rtl/servo_bus_packet_master_core.sv
rtl/sbpm_checker.sv
dv/servo_bus_packet_master_core_test.sv
